// File: sv/wsrc_pkg.sv
package wsrc_pkg;

   localparam int MAX_LEN_DEFAULT = 1024;

   localparam int LEN_W   = 11;
   localparam int SUM_W   = 32;
   localparam int STEP_W  = 20;
   localparam int COUNT_W = 27;

   // dividend width of the shared remainder unit, one bit per cycle
   localparam int DIV_W   = 32;
   localparam int DIV_CNT_W = $clog2(DIV_W);

   localparam logic [COUNT_W-1:0] COUNT_MOD = 27'd100000007;

endpackage

// File: sv/wsrc_ram.sv
module wsrc_ram #(
   parameter int WIDTH = 27,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_a_addr,
   output logic [WIDTH-1:0]         rd_a_data,
   input  logic [$clog2(DEPTH)-1:0] rd_b_addr,
   output logic [WIDTH-1:0]         rd_b_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_data <= mem_ff[rd_a_addr];
      rd_b_data <= mem_ff[rd_b_addr];
   end

endmodule

// File: sv/wave_sequence_residue_count_unit.sv
// Counts sequences of length n summing to s, each step adding a or subtracting b, modulo
// 100000007. A transaction is taken when start is high and busy is low; for a valid length busy
// then stays high until the result is ready. One request runs the shared remainder unit
// (a mod n, b mod n, s mod n), seeds row 0, sweeps the remaining rows (one residue per cycle
// through the dual-read row RAM) and reads out the result. A length of 0 or above MAX_LEN
// returns 0 on the cycle after start.
// The result appears on rsp_sequence_count for exactly one cycle with rsp_valid high; the
// receiver cannot stall it and must take it then.
module wave_sequence_residue_count_unit #(
   parameter int MAX_LEN = wsrc_pkg::MAX_LEN_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [wsrc_pkg::LEN_W-1:0]         req_seq_length,
   input  logic signed [wsrc_pkg::SUM_W-1:0]  req_target_sum,
   input  logic [wsrc_pkg::STEP_W-1:0]        req_rise_step,
   input  logic [wsrc_pkg::STEP_W-1:0]        req_fall_step,
   output logic                               rsp_valid,
   output logic [wsrc_pkg::COUNT_W-1:0]       rsp_sequence_count
);
   import wsrc_pkg::*;

   localparam int W  = $clog2(MAX_LEN);
   localparam int NW = W + 1;
   localparam int AW = $clog2(2 * MAX_LEN);

   localparam logic [3:0] ST_IDLE       = 4'd0;
   localparam logic [3:0] ST_MOD_A      = 4'd1;
   localparam logic [3:0] ST_MOD_B      = 4'd2;
   localparam logic [3:0] ST_MOD_S      = 4'd3;
   localparam logic [3:0] ST_INIT       = 4'd4;
   localparam logic [3:0] ST_ROW_END    = 4'd5;
   localparam logic [3:0] ST_ROW_SETUP  = 4'd6;
   localparam logic [3:0] ST_SWEEP      = 4'd7;
   localparam logic [3:0] ST_FINAL_RD   = 4'd8;
   localparam logic [3:0] ST_FINAL_WAIT = 4'd9;

   logic [3:0]           state_ff, state_in;
   logic [NW-1:0]        n_ff, n_in;
   logic [STEP_W-1:0]    b_ff, b_in;
   logic                 s_neg_ff, s_neg_in;
   logic [SUM_W-1:0]     s_mag_ff, s_mag_in;
   logic [DIV_W-1:0]     div_ff, div_in;
   logic [W-1:0]         rem_ff, rem_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [W-1:0]         am_ff, am_in;
   logic [W-1:0]         bm_ff, bm_in;
   logic [W-1:0]         tgt_ff, tgt_in;
   logic [W-1:0]         offa_ff, offa_in;
   logic [W-1:0]         offb_ff, offb_in;
   logic [W-1:0]         ia_ff, ia_in;
   logic [W-1:0]         ib_ff, ib_in;
   logic [W-1:0]         j_ff, j_in;
   logic [NW-1:0]        rows_left_ff, rows_left_in;
   logic                 row_ff, row_in;
   logic                 pend_ff, pend_in;
   logic [AW-1:0]        pend_addr_ff, pend_addr_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0]   rsp_count_ff, rsp_count_in;

   logic                 accept;
   logic                 bad_len;
   logic [NW-1:0]        div_t;
   logic [NW-1:0]        div_r;
   logic [W-1:0]         rem_next;
   logic [W-1:0]         offa_dec;
   logic [W-1:0]         offb_dec;
   logic [NW-1:0]        n_last;
   logic [AW-1:0]        rd_base;
   logic [AW-1:0]        wr_base;

   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   logic [COUNT_W-1:0]   wr_data;
   logic [AW-1:0]        rd_a_addr;
   logic [AW-1:0]        rd_b_addr;
   logic [COUNT_W-1:0]   rd_a_data;
   logic [COUNT_W-1:0]   rd_b_data;
   logic [COUNT_W:0]     pair_sum;
   logic [COUNT_W-1:0]   pair_red;

   assign busy               = (state_ff != ST_IDLE);
   assign accept             = start && !busy;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_sequence_count = rsp_count_ff;

   assign bad_len = (req_seq_length == '0) || (32'(req_seq_length) > 32'(MAX_LEN));

   // shared remainder unit: shift in one dividend bit, subtract n when it fits
   assign div_t    = {rem_ff, div_ff[DIV_W-1]};
   assign div_r    = (div_t >= n_ff) ? (div_t - n_ff) : div_t;
   assign rem_next = W'(div_r);

   // step the row offsets back by one multiple of a and b, modulo n
   assign offa_dec = (offa_ff >= am_ff) ? (offa_ff - am_ff)
                                        : W'(NW'(offa_ff) + n_ff - NW'(am_ff));
   assign offb_dec = (offb_ff >= bm_ff) ? (offb_ff - bm_ff)
                                        : W'(NW'(offb_ff) + n_ff - NW'(bm_ff));

   assign n_last  = n_ff - NW'(1);
   assign rd_base = row_ff ? AW'(MAX_LEN) : '0;
   assign wr_base = row_ff ? '0 : AW'(MAX_LEN);

   assign pair_sum = {1'b0, rd_a_data} + {1'b0, rd_b_data};
   assign pair_red = (pair_sum >= (COUNT_W+1)'(COUNT_MOD))
                   ? COUNT_W'(pair_sum - (COUNT_W+1)'(COUNT_MOD))
                   : COUNT_W'(pair_sum);

   always_comb begin
      rd_a_addr = rd_base + AW'((state_ff == ST_FINAL_RD) ? tgt_ff : ia_ff);
      rd_b_addr = rd_base + AW'(ib_ff);
      if (state_ff == ST_INIT) begin
         wr_en   = 1'b1;
         wr_addr = AW'(j_ff);
         wr_data = (j_ff == '0) ? COUNT_W'(1) : '0;
      end else begin
         wr_en   = pend_ff;
         wr_addr = pend_addr_ff;
         wr_data = pair_red;
      end
   end

   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      b_in         = b_ff;
      s_neg_in     = s_neg_ff;
      s_mag_in     = s_mag_ff;
      div_in       = div_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      am_in        = am_ff;
      bm_in        = bm_ff;
      tgt_in       = tgt_ff;
      offa_in      = offa_ff;
      offb_in      = offb_ff;
      ia_in        = ia_ff;
      ib_in        = ib_ff;
      j_in         = j_ff;
      rows_left_in = rows_left_ff;
      row_in       = row_ff;
      pend_in      = 1'b0;
      pend_addr_in = pend_addr_ff;
      rsp_valid_in = 1'b0;
      rsp_count_in = rsp_count_ff;

      unique case (state_ff) inside
         ST_IDLE: begin
            if (accept) begin
               if (bad_len) begin
                  rsp_valid_in = 1'b1;
                  rsp_count_in = '0;
               end else begin
                  n_in         = NW'(req_seq_length);
                  rows_left_in = NW'(req_seq_length - LEN_W'(1));
                  b_in         = req_fall_step;
                  s_neg_in     = req_target_sum[SUM_W-1];
                  s_mag_in     = req_target_sum[SUM_W-1] ? (~req_target_sum + SUM_W'(1))
                                                         : req_target_sum;
                  div_in       = DIV_W'(req_rise_step);
                  rem_in       = '0;
                  cnt_in       = '0;
                  offa_in      = '0;
                  offb_in      = '0;
                  j_in         = '0;
                  row_in       = 1'b0;
                  state_in     = ST_MOD_A;
               end
            end
         end
         ST_MOD_A, ST_MOD_B, ST_MOD_S: begin
            div_in = div_ff << 1;
            rem_in = rem_next;
            cnt_in = cnt_ff + DIV_CNT_W'(1);
            if (cnt_ff == DIV_CNT_W'(DIV_W - 1)) begin
               rem_in = '0;
               if (state_ff == ST_MOD_A) begin
                  am_in    = rem_next;
                  div_in   = DIV_W'(b_ff);
                  state_in = ST_MOD_B;
               end else if (state_ff == ST_MOD_B) begin
                  bm_in    = rem_next;
                  div_in   = s_mag_ff;
                  state_in = ST_MOD_S;
               end else begin
                  // negative sum: fold the remainder back into 0..n-1
                  tgt_in   = (s_neg_ff && rem_next != '0) ? W'(n_ff - NW'(rem_next))
                                                          : rem_next;
                  state_in = ST_INIT;
               end
            end
         end
         ST_INIT: begin
            j_in = j_ff + W'(1);
            if (NW'(j_ff) == n_last) begin
               state_in = ST_ROW_END;
            end
         end
         ST_ROW_END: begin
            if (rows_left_ff == '0) begin
               state_in = ST_FINAL_RD;
            end else begin
               offa_in      = offa_dec;
               offb_in      = offb_dec;
               rows_left_in = rows_left_ff - NW'(1);
               state_in     = ST_ROW_SETUP;
            end
         end
         ST_ROW_SETUP: begin
            ia_in    = (offa_ff == '0) ? '0 : W'(n_ff - NW'(offa_ff));
            ib_in    = offb_ff;
            j_in     = '0;
            state_in = ST_SWEEP;
         end
         ST_SWEEP: begin
            // read two entries of the previous row now, write the sum next cycle
            pend_in      = 1'b1;
            pend_addr_in = wr_base + AW'(j_ff);
            j_in         = j_ff + W'(1);
            ia_in        = (NW'(ia_ff) == n_last) ? '0 : ia_ff + W'(1);
            ib_in        = (NW'(ib_ff) == n_last) ? '0 : ib_ff + W'(1);
            if (NW'(j_ff) == n_last) begin
               row_in   = !row_ff;
               state_in = ST_ROW_END;
            end
         end
         ST_FINAL_RD: begin
            state_in = ST_FINAL_WAIT;
         end
         ST_FINAL_WAIT: begin
            rsp_valid_in = 1'b1;
            rsp_count_in = rd_a_data;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      n_ff         <= n_in;
      b_ff         <= b_in;
      s_neg_ff     <= s_neg_in;
      s_mag_ff     <= s_mag_in;
      div_ff       <= div_in;
      rem_ff       <= rem_in;
      cnt_ff       <= cnt_in;
      am_ff        <= am_in;
      bm_ff        <= bm_in;
      tgt_ff       <= tgt_in;
      offa_ff      <= offa_in;
      offb_ff      <= offb_in;
      ia_ff        <= ia_in;
      ib_ff        <= ib_in;
      j_ff         <= j_in;
      rows_left_ff <= rows_left_in;
      row_ff       <= row_in;
      pend_addr_ff <= pend_addr_in;
      rsp_count_ff <= rsp_count_in;
   end

   wsrc_ram #(
      .WIDTH (COUNT_W),
      .DEPTH (2 * MAX_LEN)
   ) u_rows (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_a_addr (rd_a_addr),
      .rd_a_data (rd_a_data),
      .rd_b_addr (rd_b_addr),
      .rd_b_data (rd_b_data)
   );

   a_sweep_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SWEEP) |-> (NW'(ia_ff) < n_ff && NW'(ib_ff) < n_ff && NW'(j_ff) < n_ff))
      else $error("sweep index outside the row");

   a_offsets_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROW_SETUP) |-> (NW'(offa_ff) < n_ff && NW'(offb_ff) < n_ff))
      else $error("row offset not reduced mod n");

   a_write_reduced: assert property (@(posedge clock) disable iff (reset)
      (wr_en && state_ff != ST_INIT) |-> (wr_data < COUNT_MOD))
      else $error("row entry written without reduction");

   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_valid))
      else $error("accepted transaction neither started nor answered");

   a_result_reduced: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_sequence_count < COUNT_MOD))
      else $error("result out of range");

endmodule

// File: tb/wave_sequence_residue_count_unit_tb.sv
module wave_sequence_residue_count_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import wsrc_pkg::*;

   localparam int MAX_LEN       = MAX_LEN_DEFAULT;
   localparam int STALL_LIMIT   = 4_500_000;
   localparam int DIRECTED_ROWS = 16;
   localparam int RANDOM_ITEMS  = 100;
   localparam int SETTLE_CYCLES = 20;

   typedef struct packed {
      logic [LEN_W-1:0]        len;
      logic signed [SUM_W-1:0] sum;
      logic [STEP_W-1:0]       rise;
      logic [STEP_W-1:0]       fall;
      bit                      typed;
      logic [COUNT_W-1:0]      count;
   } request_row_type;

   logic                    clock;
   logic                    reset;
   logic                    start;
   logic                    busy;
   logic [LEN_W-1:0]        req_seq_length;
   logic signed [SUM_W-1:0] req_target_sum;
   logic [STEP_W-1:0]       req_rise_step;
   logic [STEP_W-1:0]       req_fall_step;
   logic                    rsp_valid;
   logic [COUNT_W-1:0]      rsp_sequence_count;

   logic [COUNT_W-1:0] expected_counts[$];
   logic [COUNT_W-1:0] oldest_count;
   int unsigned        count_rows[2][MAX_LEN];
   int unsigned        failures;
   int unsigned        counts_checked;
   int unsigned        requests_sent;
   int unsigned        bad_lengths_sent;
   int unsigned        longest_len;
   int unsigned        burst_left;
   int unsigned        idle_cycles;

   // typed counts: zero for a length of 0 or above the maximum, one for a single term
   request_row_type directed_rows [DIRECTED_ROWS] = '{
      '{11'd0,    32'sd0,          20'd0,      20'd0,      1'b1, 27'd0},
      '{11'd1,    32'sh80000000,   20'hFFFFF,  20'hFFFFF,  1'b1, 27'd1},
      '{11'd1,    32'sh7FFFFFFF,   20'd0,      20'd0,      1'b1, 27'd1},
      '{11'd2047, 32'sh7FFFFFFF,   20'hFFFFF,  20'hFFFFF,  1'b1, 27'd0},
      '{11'd1025, -32'sd1,         20'd1,      20'd1,      1'b1, 27'd0},
      '{11'd2,    32'sd1,          20'd1,      20'd1,      1'b0, 27'd0},
      '{11'd2,    -32'sd1,         20'd1,      20'd1,      1'b0, 27'd0},
      '{11'd3,    32'sd0,          20'd0,      20'd0,      1'b0, 27'd0},
      '{11'd5,    -32'sd7,         20'd3,      20'd2,      1'b0, 27'd0},
      '{11'd7,    32'sh7FFFFFFF,   20'hFFFFF,  20'hFFFFF,  1'b0, 27'd0},
      '{11'd16,   32'sh80000000,   20'd0,      20'hFFFFF,  1'b0, 27'd0},
      '{11'd31,   -32'sd100,       20'hFFFFF,  20'd0,      1'b0, 27'd0},
      '{11'd1024, 32'sd12345,      20'd1,      20'd2,      1'b0, 27'd0},
      '{11'd0,    -32'sd1,         20'hFFFFF,  20'hFFFFF,  1'b1, 27'd0},
      '{11'd2,    32'sd0,          20'd0,      20'd0,      1'b0, 27'd0},
      '{11'd64,   32'sd1000,       20'd5,      20'd9,      1'b0, 27'd0}
   };

   wave_sequence_residue_count_unit #(.MAX_LEN(MAX_LEN)) dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_seq_length     (req_seq_length),
      .req_target_sum     (req_target_sum),
      .req_rise_step      (req_rise_step),
      .req_fall_step      (req_fall_step),
      .rsp_valid          (rsp_valid),
      .rsp_sequence_count (rsp_sequence_count)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // residue-class DP over rows 1..n-1, two rows ping-ponged
   function automatic logic [COUNT_W-1:0] predict_count(
      input logic [LEN_W-1:0]        len,
      input logic signed [SUM_W-1:0] sum,
      input logic [STEP_W-1:0]       rise,
      input logic [STEP_W-1:0]       fall);
      int unsigned n, am, bm, offa, offb, ia, ib, k;
      int          cur, i, j;
      longint      rem;
      n = len;
      if (n == 0 || n > MAX_LEN) return '0;
      for (j = 0; j < n; j++) count_rows[0][j] = (j == 0) ? 1 : 0;
      am  = rise % n;
      bm  = fall % n;
      cur = 0;
      for (i = 1; i < n; i++) begin
         k    = n - i;
         offa = (am * k) % n;
         offb = (bm * k) % n;
         for (j = 0; j < n; j++) begin
            ia = (j + n - offa) % n;
            ib = (j + offb) % n;
            count_rows[cur ^ 1][j] = (count_rows[cur][ia] + count_rows[cur][ib]) % COUNT_MOD;
         end
         cur = cur ^ 1;
      end
      rem = longint'(sum) % longint'(n);
      if (rem < 0) rem = rem + n;
      return count_rows[cur][rem][COUNT_W-1:0];
   endfunction

   task automatic issue_request(
      input logic [LEN_W-1:0]        len,
      input logic signed [SUM_W-1:0] sum,
      input logic [STEP_W-1:0]       rise,
      input logic [STEP_W-1:0]       fall,
      input bit                      typed,
      input logic [COUNT_W-1:0]      typed_count);
      int unsigned gap;
      @(negedge clock);
      start          <= 1'b1;
      req_seq_length <= len;
      req_target_sum <= sum;
      req_rise_step  <= rise;
      req_fall_step  <= fall;
      @(posedge clock);
      while (busy) @(posedge clock);
      expected_counts.push_back(typed ? typed_count : predict_count(len, sum, rise, fall));
      requests_sent++;
      if (len == 0 || len > MAX_LEN) bad_lengths_sent++;
      else if (len > longest_len) longest_len = len;
      // keep start high inside a burst, drop it for the gap between bursts
      if (burst_left != 0) begin
         burst_left--;
         gap = 0;
      end else begin
         burst_left = $urandom_range(0, 7);
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 400) : $urandom_range(1, 12);
      end
      repeat (gap) begin
         @(negedge clock);
         start <= 1'b0;
      end
   endtask

   task automatic drain_counts();
      @(negedge clock);
      start <= 1'b0;
      while (expected_counts.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if ((start && !busy) || rsp_valid) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (rsp_valid) begin
            counts_checked++;
            if (expected_counts.size() == 0) begin
               failures++;
               $display("%0t: unexpected sequence_count, expected none, got %0d",
                        $time, rsp_sequence_count);
            end else begin
               oldest_count = expected_counts.pop_front();
               if (rsp_sequence_count !== oldest_count) begin
                  failures++;
                  $display("%0t: sequence_count mismatch, expected %0d, got %0d",
                           $time, oldest_count, rsp_sequence_count);
               end
            end
         end
      end
   end

   initial begin
      while (reset !== 1'b0 || idle_cycles < STALL_LIMIT) @(posedge clock);
      $display("%0t: no transaction for %0d cycles, %0d counts outstanding",
               $time, STALL_LIMIT, expected_counts.size());
      $display("Verification failed");
      $finish;
   end

   initial begin
      int unsigned             row, item;
      logic [LEN_W-1:0]        len;
      logic signed [SUM_W-1:0] sum;
      logic [STEP_W-1:0]       rise, fall;
      reset            = 1'b1;
      start            = 1'b0;
      req_seq_length   = '0;
      req_target_sum   = '0;
      req_rise_step    = '0;
      req_fall_step    = '0;
      failures         = 0;
      counts_checked   = 0;
      requests_sent    = 0;
      bad_lengths_sent = 0;
      longest_len      = 0;
      burst_left       = 0;
      idle_cycles      = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (row = 0; row < DIRECTED_ROWS; row++) begin
         issue_request(directed_rows[row].len, directed_rows[row].sum, directed_rows[row].rise,
                       directed_rows[row].fall, directed_rows[row].typed,
                       directed_rows[row].count);
      end
      drain_counts();

      for (item = 0; item < RANDOM_ITEMS; item++) begin
         // mostly short lengths, a few medium ones, some out of range
         case ($urandom_range(0, 19)) inside
            0:       len = ($urandom_range(0, 1) == 0)
                         ? '0 : LEN_W'($urandom_range(MAX_LEN + 1, 2047));
            1, 2:    len = LEN_W'($urandom_range(65, 250));
            default: len = LEN_W'($urandom_range(1, 40));
         endcase
         if ($urandom_range(0, 1) == 0) sum = $urandom;
         else sum = $urandom_range(0, 64) - 32;
         rise = ($urandom_range(0, 2) == 0) ? STEP_W'($urandom_range(0, 9)) : STEP_W'($urandom);
         fall = ($urandom_range(0, 2) == 0) ? STEP_W'($urandom_range(0, 9)) : STEP_W'($urandom);
         issue_request(len, sum, rise, fall, 1'b0, '0);
         if (item == RANDOM_ITEMS / 2) drain_counts();
      end
      drain_counts();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Sent %0d requests (%0d with a length of 0 or above %0d, longest valid length %0d).",
               requests_sent, bad_lengths_sent, MAX_LEN, longest_len);
      $display("Checked %0d counts, %0d failures.", counts_checked, failures);
      if (failures == 0 && expected_counts.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// File: wave_sequence_residue_count_unit.f
sv/wsrc_pkg.sv
sv/wsrc_ram.sv
sv/wave_sequence_residue_count_unit.sv
tb/wave_sequence_residue_count_unit_tb.sv
